@@ design/knp_pkg.sv @@
package knp_pkg;

  // list and field geometry
  localparam int NEAREST_COUNT = 8;
  localparam int INDEX_BITS    = 10;
  localparam int COORD_W       = 20;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * COORD_W;
  localparam int DIST_W        = 44;
  localparam int IDX_OUT_W     = 10;
  localparam int RANK_W        = 3;
  localparam int CNT_W         = (NEAREST_COUNT > 1) ? $clog2(NEAREST_COUNT) : 1;
  localparam int CFG_ADDR_W    = 2;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_REF_X = 2'd0,
    CFG_REF_Y = 2'd1,
    CFG_REF_Z = 2'd2
  } cfg_reg_t;

  // input transaction
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [IDX_OUT_W-1:0]      point_index;
    logic                      final_point;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [RANK_W-1:0]    rank;
    logic [IDX_OUT_W-1:0] chosen_index;
    logic                 found;
    logic [DIST_W-1:0]    nearest_distance;
    logic                 last_rank;
  } out_item_t;

  // one held list entry
  typedef struct packed {
    logic                  valid;
    logic [DIST_W-1:0]     distance;
    logic [INDEX_BITS-1:0] idx;
  } entry_t;

  // candidate leaving the distance pipeline
  typedef struct packed {
    logic                  valid;
    logic                  final_point;
    logic [DIST_W-1:0]     distance;
    logic [INDEX_BITS-1:0] idx;
  } cand_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, distance: '1, idx: '0};

endpackage

@@ design/nearest_k_point_selector_core.sv @@
// Keeps the eight points nearest to a reference point (squared Euclidean
// distance, Q28.16) out of a stream of Q12.8 points, using a row of sorted
// insertion cells. Ordinary points are taken one per cycle with no gaps; each
// passes three registered stages (difference, square, sum) before the list.
// A point with final_point set closes the set: input stalls while it passes
// the three distance stages, then the row shifts out one rank per cycle while
// the output register is free, closest first, eight results ending with
// last_rank. Input stays stalled until the last rank is loaded, longer if
// out_stall holds the output register. Draining empties the list for the next
// set. The user must write the reference point registers through the cfg
// port only while the block is idle; the block does not enforce it. Index 3 is ignored.
module nearest_k_point_selector_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  knp_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output knp_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [knp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [knp_pkg::COORD_W-1:0]      cfg_wdata
);

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_WAIT  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                             state_r, state_nxt;
  logic signed [knp_pkg::COORD_W-1:0] ref_x_r, ref_y_r, ref_z_r;
  logic [knp_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                               out_valid_r, out_valid_nxt;
  knp_pkg::out_item_t                 out_data_r, out_data_nxt;
  logic                               in_take;
  logic                               load;
  logic                               last_load;
  knp_pkg::cand_t                     cand;
  knp_pkg::cell_ctl_t                 ctl;
  knp_pkg::entry_t                    ent    [knp_pkg::NEAREST_COUNT];
  logic                               take   [knp_pkg::NEAREST_COUNT];
  knp_pkg::entry_t                    prev_e [knp_pkg::NEAREST_COUNT];
  logic                               prev_t [knp_pkg::NEAREST_COUNT];
  knp_pkg::entry_t                    next_e [knp_pkg::NEAREST_COUNT];

  // reference point registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= '0;
      ref_y_r <= '0;
      ref_z_r <= '0;
    end else if (cfg_we) begin
      case (knp_pkg::cfg_reg_t'(cfg_addr))
        knp_pkg::CFG_REF_X: ref_x_r <= cfg_wdata;
        knp_pkg::CFG_REF_Y: ref_y_r <= cfg_wdata;
        knp_pkg::CFG_REF_Z: ref_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input side
  assign in_stall = (state_r != ST_RUN);
  assign in_take  = in_valid && !in_stall;

  knp_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_take),
    .item  (in_data),
    .ref_x (ref_x_r),
    .ref_y (ref_y_r),
    .ref_z (ref_z_r),
    .cand  (cand)
  );

  // drain moves one rank into the output register when it is free
  assign load      = (state_r == ST_DRAIN) && (!out_valid_r || !out_stall);
  assign last_load = load && (cnt_r == knp_pkg::CNT_W'(knp_pkg::NEAREST_COUNT - 1));
  assign ctl       = knp_pkg::cell_ctl_t'{insert: cand.valid, shift: load};

  // neighbor wiring of the cell row
  always_comb begin
    for (int k = 0; k < knp_pkg::NEAREST_COUNT; k++) begin
      prev_e[k] = (k == 0) ? knp_pkg::EMPTY_ENTRY : ent[(k == 0) ? 0 : k - 1];
      prev_t[k] = (k == 0) ? 1'b0 : take[(k == 0) ? 0 : k - 1];
      next_e[k] = (k == knp_pkg::NEAREST_COUNT - 1) ? knp_pkg::EMPTY_ENTRY
                : ent[(k == knp_pkg::NEAREST_COUNT - 1) ? k : k + 1];
    end
  end

  for (genvar g = 0; g < knp_pkg::NEAREST_COUNT; g++) begin : g_cell
    knp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_dist  (cand.distance),
      .new_idx   (cand.idx),
      .prev_take (prev_t[g]),
      .prev_ent  (prev_e[g]),
      .next_ent  (next_e[g]),
      .ent       (ent[g]),
      .take      (take[g])
    );
  end

  // sequencer: run, wait for the final point to reach the row, drain
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_RUN: begin
        if (in_take && in_data.final_point) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (cand.valid && cand.final_point) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (last_load) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end else if (load) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_RUN;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.rank             = knp_pkg::RANK_W'(cnt_r);
      out_data_nxt.found            = ent[0].valid;
      out_data_nxt.chosen_index     = ent[0].valid ? knp_pkg::IDX_OUT_W'(ent[0].idx) : '0;
      out_data_nxt.nearest_distance = ent[0].valid ? ent[0].distance : '1;
      out_data_nxt.last_rank        = last_load;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the final point only arrives while input is held off for it
  a_final_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (cand.valid && cand.final_point) |-> (state_r == ST_WAIT))
    else $error("final point reached the list outside the wait state");

  // nothing is still in the distance pipeline while the list drains
  a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> !cand.valid)
    else $error("candidate arrived during drain");

  // the last rank is loaded together with the exit from drain
  a_last_exit: assert property (@(posedge clk) disable iff (!rst_n)
    last_load |=> (state_r == ST_RUN))
    else $error("still draining after last rank");

  // the two nearest ranks stay ordered and packed toward rank 0
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ent[knp_pkg::NEAREST_COUNT > 1 ? 1 : 0].valid |->
      (ent[0].valid &&
       (ent[0].distance <= ent[knp_pkg::NEAREST_COUNT > 1 ? 1 : 0].distance)))
    else $error("nearest list out of order");

endmodule

@@ design/knp_dist.sv @@
module knp_dist (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  knp_pkg::in_item_t                 item,
  input  logic signed [knp_pkg::COORD_W-1:0] ref_x,
  input  logic signed [knp_pkg::COORD_W-1:0] ref_y,
  input  logic signed [knp_pkg::COORD_W-1:0] ref_z,
  output knp_pkg::cand_t                    cand
);

  logic signed [knp_pkg::DIFF_W-1:0]   dx, dy, dz;
  logic [knp_pkg::DIFF_W-1:0]          ax, ay, az;
  logic [knp_pkg::COORD_W-1:0]         mx_r, my_r, mz_r;
  logic [knp_pkg::SQ_W-1:0]            sx_r, sy_r, sz_r;
  logic [knp_pkg::INDEX_BITS-1:0]      idx1_r, idx2_r;
  logic                                fin1_r, fin2_r;
  logic                                v1_r, v2_r;
  knp_pkg::cand_t                      cand_r;

  // stage 1: coordinate differences and magnitudes
  always_comb begin
    dx = {item.point_x[knp_pkg::COORD_W-1], item.point_x} - {ref_x[knp_pkg::COORD_W-1], ref_x};
    dy = {item.point_y[knp_pkg::COORD_W-1], item.point_y} - {ref_y[knp_pkg::COORD_W-1], ref_y};
    dz = {item.point_z[knp_pkg::COORD_W-1], item.point_z} - {ref_z[knp_pkg::COORD_W-1], ref_z};
    ax = dx[knp_pkg::DIFF_W-1] ? (~dx + 1'b1) : dx;
    ay = dy[knp_pkg::DIFF_W-1] ? (~dy + 1'b1) : dy;
    az = dz[knp_pkg::DIFF_W-1] ? (~dz + 1'b1) : dz;
  end

  always_ff @(posedge clk) begin
    mx_r   <= ax[knp_pkg::COORD_W-1:0];
    my_r   <= ay[knp_pkg::COORD_W-1:0];
    mz_r   <= az[knp_pkg::COORD_W-1:0];
    idx1_r <= knp_pkg::INDEX_BITS'(item.point_index);
    fin1_r <= item.final_point;
  end

  // stage 2: one multiplier per axis
  always_ff @(posedge clk) begin
    sx_r   <= mx_r * mx_r;
    sy_r   <= my_r * my_r;
    sz_r   <= mz_r * mz_r;
    idx2_r <= idx1_r;
    fin2_r <= fin1_r;
  end

  // stage 3: sum of squares
  always_ff @(posedge clk) begin
    cand_r.distance    <= knp_pkg::DIST_W'(sx_r) + knp_pkg::DIST_W'(sy_r)
                          + knp_pkg::DIST_W'(sz_r);
    cand_r.idx         <= idx2_r;
    cand_r.final_point <= fin2_r;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      cand_r.valid <= 1'b0;
    end else begin
      v1_r         <= take;
      v2_r         <= v1_r;
      cand_r.valid <= v2_r;
    end
  end

  assign cand = cand_r;

endmodule

@@ design/knp_cell.sv @@
module knp_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  knp_pkg::cell_ctl_t             ctl,
  input  logic [knp_pkg::DIST_W-1:0]     new_dist,
  input  logic [knp_pkg::INDEX_BITS-1:0] new_idx,
  input  logic                           prev_take,
  input  knp_pkg::entry_t                prev_ent,
  input  knp_pkg::entry_t                next_ent,
  output knp_pkg::entry_t                ent,
  output logic                           take
);

  knp_pkg::entry_t ent_r, ent_nxt;

  // the new point lands here or further up the chain
  assign take = ctl.insert && (!ent_r.valid || (new_dist < ent_r.distance));

  // shift out toward rank 0, or insert / push down from the left neighbor
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.shift) begin
      ent_nxt = next_ent;
    end else if (take) begin
      if (prev_take) begin
        ent_nxt = prev_ent;
      end else begin
        ent_nxt.valid    = 1'b1;
        ent_nxt.distance = new_dist;
        ent_nxt.idx      = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= knp_pkg::EMPTY_ENTRY;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

@@ bench/tb_nearest_k_point_selector_core.sv @@
`timescale 1ns / 1ps

module tb_nearest_k_point_selector_core;

  localparam int unsigned LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_POINTS = 50;
  localparam logic [knp_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [knp_pkg::COORD_W-1:0] COORD_MIN = 20'sh80000;
  localparam logic signed [knp_pkg::COORD_W-1:0] COORD_MAX = 20'sh7FFFF;

  // directed rows: a reference setting, a point checked by the predictor, or
  // a one-point set whose closest rank is typed in
  typedef enum logic [1:0] {ROW_REFS, ROW_POINT, ROW_LONE} row_kind_t;

  typedef struct {
    row_kind_t                          kind;
    logic signed [knp_pkg::COORD_W-1:0] x;
    logic signed [knp_pkg::COORD_W-1:0] y;
    logic signed [knp_pkg::COORD_W-1:0] z;
    logic [knp_pkg::IDX_OUT_W-1:0]      idx;
    logic                               fin;
    logic [knp_pkg::DIST_W-1:0]         lone_dist;
  } step_t;

  step_t script [0:23] = '{
    // reset reference is the origin
    '{ROW_LONE, 20'sh00000, 20'sh00000, 20'sh00000, 10'd0, 1'b1, 44'h000_0000_0000},
    '{ROW_LONE, COORD_MIN, COORD_MIN, COORD_MIN, 10'h3FF, 1'b1, 44'h0C0_0000_0000},
    '{ROW_LONE, COORD_MAX, COORD_MAX, COORD_MAX, 10'd5, 1'b1, 44'h0BF_FFD0_0003},
    // farthest possible point
    '{ROW_REFS, COORD_MAX, COORD_MAX, COORD_MAX, 10'd0, 1'b0, 44'h0},
    '{ROW_LONE, COORD_MIN, COORD_MIN, COORD_MIN, 10'h2AA, 1'b1, 44'h2FF_FFA0_0003},
    // ties, full list, dropped point, push-out
    '{ROW_POINT, COORD_MAX - 20'sd5, COORD_MAX, COORD_MAX, 10'd10, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX - 20'sd5, COORD_MAX, COORD_MAX, 10'd11, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX - 20'sd3, COORD_MAX, COORD_MAX, 10'd12, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX - 20'sd9, COORD_MAX, COORD_MAX, 10'd13, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX - 20'sd1, COORD_MAX, COORD_MAX, 10'd14, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX - 20'sd7, COORD_MAX, COORD_MAX, 10'd15, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX - 20'sd5, COORD_MAX, COORD_MAX, 10'd16, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX - 20'sd2, COORD_MAX, COORD_MAX, 10'd17, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX - 20'sd100, COORD_MAX, COORD_MAX, 10'd18, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 10'd19, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX - 20'sd5, COORD_MAX, COORD_MAX, 10'd20, 1'b1, 44'h0},
    // partly filled list leaves empty ranks
    '{ROW_POINT, 20'sh00000, 20'sh00000, 20'sh00000, 10'd100, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX, COORD_MAX, 20'sh00000, 10'd101, 1'b0, 44'h0},
    '{ROW_POINT, COORD_MAX, 20'sh00000, COORD_MAX, 10'd102, 1'b1, 44'h0},
    '{ROW_REFS, COORD_MIN, COORD_MIN, COORD_MIN, 10'd0, 1'b0, 44'h0},
    '{ROW_LONE, COORD_MAX, COORD_MAX, COORD_MAX, 10'h155, 1'b1, 44'h2FF_FFA0_0003},
    // mixed reference, tie on both sides of it
    '{ROW_REFS, 20'sh12345, 20'shABCDE, 20'sh00F0F, 10'd0, 1'b0, 44'h0},
    '{ROW_POINT, 20'sh12346, 20'shABCDE, 20'sh00F0F, 10'd7, 1'b0, 44'h0},
    '{ROW_POINT, 20'sh12344, 20'shABCDE, 20'sh00F0F, 10'd3, 1'b1, 44'h0}
  };

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  knp_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  knp_pkg::out_item_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [knp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [knp_pkg::COORD_W-1:0]    cfg_wdata = '0;

  // predictor copy of the reference point and the nearest list
  logic signed [knp_pkg::COORD_W-1:0] ref_x = '0;
  logic signed [knp_pkg::COORD_W-1:0] ref_y = '0;
  logic signed [knp_pkg::COORD_W-1:0] ref_z = '0;
  logic [knp_pkg::DIST_W-1:0]         near_dist [knp_pkg::NEAREST_COUNT];
  logic [knp_pkg::IDX_OUT_W-1:0]      near_idx [knp_pkg::NEAREST_COUNT];
  logic                               near_used [knp_pkg::NEAREST_COUNT];

  knp_pkg::out_item_t expected_ranks [$];
  int unsigned in_gap_pct = 17;
  int unsigned out_stall_pct = 60;
  int unsigned errors = 0;
  int unsigned points_sent = 0;
  int unsigned sets_closed = 0;
  int unsigned ranks_checked = 0;
  int unsigned ref_settings = 0;
  int unsigned cycle_count = 0;

  nearest_k_point_selector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_nearest();
    int k;
    for (k = 0; k < knp_pkg::NEAREST_COUNT; k++) begin
      near_dist[k] = '1;
      near_idx[k]  = '0;
      near_used[k] = 1'b0;
    end
  endfunction

  // insert one point; a final point also queues its ranks if queue_ranks is set, and clears the list
  function automatic void rank_point(input knp_pkg::in_item_t pt, input bit queue_ranks);
    longint dx;
    longint dy;
    longint dz;
    logic [knp_pkg::DIST_W-1:0] d;
    int slot;
    int k;
    knp_pkg::out_item_t r;
    dx = longint'($signed(pt.point_x)) - longint'(ref_x);
    dy = longint'($signed(pt.point_y)) - longint'(ref_y);
    dz = longint'($signed(pt.point_z)) - longint'(ref_z);
    d = knp_pkg::DIST_W'(dx * dx + dy * dy + dz * dz);
    slot = knp_pkg::NEAREST_COUNT;
    for (k = 0; k < knp_pkg::NEAREST_COUNT; k++)
      if (slot == knp_pkg::NEAREST_COUNT && (!near_used[k] || d < near_dist[k])) slot = k;
    if (slot < knp_pkg::NEAREST_COUNT) begin
      for (k = knp_pkg::NEAREST_COUNT - 1; k > slot; k--) begin
        near_dist[k] = near_dist[k-1];
        near_idx[k]  = near_idx[k-1];
        near_used[k] = near_used[k-1];
      end
      near_dist[slot] = d;
      near_idx[slot]  = pt.point_index;
      near_used[slot] = 1'b1;
    end
    if (pt.final_point) begin
      sets_closed++;
      if (queue_ranks)
        for (k = 0; k < knp_pkg::NEAREST_COUNT; k++) begin
          r.rank             = knp_pkg::RANK_W'(k);
          r.chosen_index     = near_used[k] ? near_idx[k] : '0;
          r.found            = near_used[k];
          r.nearest_distance = near_used[k] ? near_dist[k] : '1;
          r.last_rank        = (k == knp_pkg::NEAREST_COUNT - 1);
          expected_ranks.push_back(r);
        end
      clear_nearest();
    end
  endfunction

  function automatic logic [knp_pkg::COORD_W-1:0] pick_coord(
      input logic [knp_pkg::COORD_W-1:0] center, input int unsigned style);
    case (style)
      0, 1, 2, 3:
        return center + knp_pkg::COORD_W'($urandom_range(8)) - knp_pkg::COORD_W'(4);
      4, 5, 6:
        return center + knp_pkg::COORD_W'($urandom_range(4000)) - knp_pkg::COORD_W'(2000);
      7, 8:       return knp_pkg::COORD_W'($urandom);
      default:    return $urandom_range(1) ? COORD_MAX : COORD_MIN;
    endcase
  endfunction

  // one input transaction, with a random gap ahead of it
  task automatic send_point(input knp_pkg::in_item_t pt);
    if ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
  endtask

  // drop valid, wait for every rank to come back, let the pipeline drain
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three reference registers, then junk to the unused index
  task automatic load_refs(input logic [knp_pkg::COORD_W-1:0] x,
                           input logic [knp_pkg::COORD_W-1:0] y,
                           input logic [knp_pkg::COORD_W-1:0] z);
    cfg_we    <= 1'b1;
    cfg_addr  <= knp_pkg::CFG_REF_X;
    cfg_wdata <= x;
    @(posedge clk);
    cfg_addr  <= knp_pkg::CFG_REF_Y;
    cfg_wdata <= y;
    @(posedge clk);
    cfg_addr  <= knp_pkg::CFG_REF_Z;
    cfg_wdata <= z;
    @(posedge clk);
    cfg_addr  <= CFG_SPARE;
    cfg_wdata <= knp_pkg::COORD_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    ref_x = x;
    ref_y = y;
    ref_z = z;
    ref_settings++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic check_rank(input knp_pkg::out_item_t got);
    knp_pkg::out_item_t want;
    if (expected_ranks.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, rank %0d index %0d distance 0x%0h", $time,
               got.rank, got.chosen_index, got.nearest_distance);
      return;
    end
    want = expected_ranks.pop_front();
    compare_field("rank", 64'(want.rank), 64'(got.rank));
    compare_field("chosen_index", 64'(want.chosen_index), 64'(got.chosen_index));
    compare_field("found", 64'(want.found), 64'(got.found));
    compare_field("nearest_distance", 64'(want.nearest_distance), 64'(got.nearest_distance));
    compare_field("last_rank", 64'(want.last_rank), 64'(got.last_rank));
    ranks_checked++;
  endtask

  // result side: check the accepted transaction, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_rank(out_data);
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d ranks still outstanding", cycle_count,
             expected_ranks.size());
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin
    knp_pkg::in_item_t pt;
    int unsigned ph;
    int unsigned k;
    int unsigned style;
    int unsigned remaining;
    int unsigned set_len;
    clear_nearest();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (script[i]) begin
      if (script[i].kind == ROW_REFS) begin
        settle_idle();
        load_refs(script[i].x, script[i].y, script[i].z);
      end else begin
        pt.point_x     = script[i].x;
        pt.point_y     = script[i].y;
        pt.point_z     = script[i].z;
        pt.point_index = script[i].idx;
        pt.final_point = script[i].fin;
        send_point(pt);
        rank_point(pt, script[i].kind == ROW_POINT);
        if (script[i].kind == ROW_LONE)
          for (k = 0; k < knp_pkg::NEAREST_COUNT; k++)
            expected_ranks.push_back(knp_pkg::out_item_t'{
              rank:             knp_pkg::RANK_W'(k),
              chosen_index:     (k == 0) ? script[i].idx : {knp_pkg::IDX_OUT_W{1'b0}},
              found:            (k == 0),
              nearest_distance: (k == 0) ? script[i].lone_dist : {knp_pkg::DIST_W{1'b1}},
              last_rank:        (k == knp_pkg::NEAREST_COUNT - 1)});
      end
    end
    settle_idle();

    // random sets, two phases per idle mode
    for (ph = 0; ph < 6; ph++) begin
      in_gap_pct    = (ph < 2) ? 17 : (ph < 4) ? 60 : 0;
      out_stall_pct = (ph < 2) ? 60 : (ph < 4) ? 17 : 0;
      case (ph)
        1:       load_refs(COORD_MIN, COORD_MIN, COORD_MIN);
        2:       load_refs(COORD_MAX, COORD_MAX, COORD_MAX);
        4:       load_refs(COORD_MIN, COORD_MAX, '0);
        default: load_refs(knp_pkg::COORD_W'($urandom), knp_pkg::COORD_W'($urandom),
                           knp_pkg::COORD_W'($urandom));
      endcase
      remaining = PHASE_POINTS;
      while (remaining > 0) begin
        set_len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(10, 1);
        if (set_len > remaining) set_len = remaining;
        for (k = 0; k < set_len; k++) begin
          style          = $urandom_range(9);
          pt.point_x     = pick_coord(ref_x, style);
          pt.point_y     = pick_coord(ref_y, style);
          pt.point_z     = pick_coord(ref_z, style);
          pt.point_index = knp_pkg::IDX_OUT_W'($urandom);
          pt.final_point = (k == set_len - 1);
          send_point(pt);
          rank_point(pt, 1'b1);
        end
        remaining -= set_len;
      end
      settle_idle();
    end

    $display("covered %0d points in %0d sets under %0d reference settings", points_sent,
             sets_closed, ref_settings);
    $display("checked %0d ranks with %0d mismatches", ranks_checked, errors);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
